### rtl/crcdme_pkg.sv
// Package for the differential Manchester encoder with CRC-16 trailer.
// Holds the sequencer state type and the CRC and line-code functions.
// No dependencies.
`timescale 1ns / 1ps

package crcdme_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;

  // Symbol pairs per bit and phase
  localparam logic [1:0] PairOnePh0  = 2'b01;
  localparam logic [1:0] PairOnePh1  = 2'b10;
  localparam logic [1:0] PairZeroPh0 = 2'b00;
  localparam logic [1:0] PairZeroPh1 = 2'b11;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_CRC_HI,
    ST_CRC_LO
  } seq_state_e;

  typedef struct packed {
    logic [15:0] word;
    logic        phase;
  } line_code_t;

  // One byte through the CRC, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int n = 0; n < 8; n++) begin
      fb = c[15] ^ data[7-n];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Differential Manchester code of one byte, first bit in the top pair;
  // each zero bit flips the phase after its pair.
  function automatic line_code_t line_code(input logic [7:0] data, input logic phase);
    line_code_t r;
    logic       ph;
    logic [1:0] pair;
    ph     = phase;
    r.word = '0;
    for (int n = 0; n < 8; n++) begin
      if (data[7-n]) begin
        pair = ph ? PairOnePh1 : PairOnePh0;
      end else begin
        pair = ph ? PairZeroPh1 : PairZeroPh0;
        ph   = ~ph;
      end
      r.word = {r.word[13:0], pair};
    end
    r.phase = ph;
    return r;
  endfunction

endpackage

### rtl/crcdme_in_if.sv
// Input channel: one payload byte and its last-byte flag per transfer.
// Standalone, no package needed.
`timescale 1ns / 1ps

interface crcdme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/crcdme_out_if.sv
// Output channel: one 16-bit line-coded word and the frame-end flag per transfer.
// Standalone, no package needed.
`timescale 1ns / 1ps

interface crcdme_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;
  logic        frame_end;

  modport source (output valid, output code_word, output frame_end, input ready);
  modport sink   (input valid, input code_word, input frame_end, output ready);
endinterface

### rtl/crc16_diff_manchester_encoder_top.sv
// Top level of the differential Manchester encoder with CRC-16/XMODEM trailer.
// Uses crcdme_pkg and the crcdme_in_if / crcdme_out_if channel interfaces.
//
// Usage:
//   in_i  takes payload bytes, MSB first, with last_byte set on the final
//         byte of a frame. A transfer happens when valid and ready are high.
//   out_o gives one 16-bit coded word per transfer. A normal byte gives one
//         word; a last byte gives its word, then the coded CRC high byte,
//         then the coded CRC low byte with frame_end set.
//   Output: each word is registered and is on out_o in the cycle after its byte is taken.
//   Throughput: one byte per cycle while out_o keeps up. A last byte holds
//         in_i ready low while the CRC words are issued from the single
//         output register.
//   After the CRC low word, CRC and coding phase start over at zero.
//   Reset: output empty, CRC and phase cleared, ready to take a byte.
//   Stall: the output register holds its word while out_o.ready is low;
//         in_i.ready drops in the same cycle, so nothing is lost.
`timescale 1ns / 1ps

module crc16_diff_manchester_encoder_top
  import crcdme_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  crcdme_in_if.sink     in_i,
  crcdme_out_if.source  out_o
);

  seq_state_e  state_q, state_d;
  logic [15:0] crc_q, crc_d;
  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] word_q, word_d;
  logic        end_q, end_d;

  logic        slot_free;
  logic        in_fire;
  logic        load;
  logic [15:0] crc_next;
  line_code_t  lc_in;
  line_code_t  lc_crc;
  logic [7:0]  crc_byte;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_DATA) && slot_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign crc_next = crc_feed(crc_q, in_i.data_byte);
  assign lc_in    = line_code(in_i.data_byte, phase_q);
  assign crc_byte = (state_q == ST_CRC_HI) ? crc_q[15:8] : crc_q[7:0];
  assign lc_crc   = line_code(crc_byte, phase_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_DATA: begin
        if (in_fire && in_i.last_byte) state_d = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        if (slot_free) state_d = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        if (slot_free) state_d = ST_DATA;
      end
      default: state_d = ST_DATA;
    endcase
  end

  // Datapath and output loads
  always_comb begin
    crc_d   = crc_q;
    phase_d = phase_q;
    load    = 1'b0;
    word_d  = word_q;
    end_d   = end_q;
    unique case (state_q)
      ST_DATA: begin
        if (in_fire) begin
          crc_d   = crc_next;
          phase_d = lc_in.phase;
          load    = 1'b1;
          word_d  = lc_in.word;
          end_d   = 1'b0;
        end
      end
      ST_CRC_HI: begin
        if (slot_free) begin
          phase_d = lc_crc.phase;
          load    = 1'b1;
          word_d  = lc_crc.word;
          end_d   = 1'b0;
        end
      end
      ST_CRC_LO: begin
        if (slot_free) begin
          crc_d   = '0;
          phase_d = 1'b0;
          load    = 1'b1;
          word_d  = lc_crc.word;
          end_d   = 1'b1;
        end
      end
      default: begin
        crc_d   = crc_q;
        phase_d = phase_q;
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DATA;
      crc_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      crc_q       <= crc_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    end_q  <= end_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.code_word = word_q;
  assign out_o.frame_end = end_q;

endmodule

### tb/tb.sv
// Self-checking testbench for crc16_diff_manchester_encoder_top: random payload frames are
// predicted in-bench (CRC-16/XMODEM plus differential Manchester) and checked per word.
// Depends on crcdme_pkg, crcdme_in_if and crcdme_out_if from the RTL.
`timescale 1ns / 1ps

module tb
  import crcdme_pkg::*;
();

  localparam int RandItems   = 380;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] word;
    logic        frame_end;
  } coded_word_t;

  logic clk_i;
  logic rst_ni;

  crcdme_in_if  in_if ();
  crcdme_out_if out_if ();

  crc16_diff_manchester_encoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  byte_item_t  byte_q[$];
  coded_word_t coded_q[$];
  byte_item_t  next_byte;

  logic [15:0] crc_acc;
  logic        line_phase;
  int          in_idle_pct;
  int          out_idle_pct;
  int          n_bytes;
  int          n_taken;
  int          err_cnt;
  int          quiet_cycles;

  always #5 clk_i = ~clk_i;

  // CRC-16/XMODEM over one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        msb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      msb = acc[15];
      acc = acc << 1;
      if (msb != b[i]) begin
        acc = acc ^ CrcPoly;
      end
    end
    return acc;
  endfunction

  // Line code of one byte; advances the running phase
  task automatic encode_byte(input logic [7:0] b, output logic [15:0] w);
    w = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        w = {w[13:0], (line_phase ? PairOnePh1 : PairOnePh0)};
      end else begin
        w = {w[13:0], (line_phase ? PairZeroPh1 : PairZeroPh0)};
        line_phase = ~line_phase;
      end
    end
  endtask

  task automatic predict_words(input byte_item_t it);
    logic [15:0] w;
    crc_acc = crc16_byte(crc_acc, it.data);
    encode_byte(it.data, w);
    coded_q.push_back('{word: w, frame_end: 1'b0});
    if (it.last) begin
      encode_byte(crc_acc[15:8], w);
      coded_q.push_back('{word: w, frame_end: 1'b0});
      encode_byte(crc_acc[7:0], w);
      coded_q.push_back('{word: w, frame_end: 1'b1});
      crc_acc    = '0;
      line_phase = 1'b0;
    end
  endtask

  task automatic add_byte(input logic [7:0] d, input logic l);
    byte_q.push_back('{data: d, last: l});
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h55;
      3:       return 8'hAA;
      4:       return 8'h01 << $urandom_range(7);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Byte source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= '0;
      in_if.last_byte <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        next_byte = byte_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.data_byte <= next_byte.data;
        in_if.last_byte <= next_byte.last;
      end else begin
        in_if.valid     <= 1'b0;
        in_if.data_byte <= 8'($urandom_range(255));
        in_if.last_byte <= 1'($urandom_range(1));
      end
    end
  end

  // Word sink backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Predict on byte transfers, check on word transfers, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_words('{data: in_if.data_byte, last: in_if.last_byte});
        n_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (coded_q.size() == 0) begin
          $error("unexpected word: code_word=%h frame_end=%b",
                 out_if.code_word, out_if.frame_end);
          err_cnt++;
        end else begin
          if (out_if.code_word !== coded_q[0].word) begin
            $error("code_word mismatch: expected %h, actual %h",
                   coded_q[0].word, out_if.code_word);
            err_cnt++;
          end
          if (out_if.frame_end !== coded_q[0].frame_end) begin
            $error("frame_end mismatch: expected %b, actual %b",
                   coded_q[0].frame_end, out_if.frame_end);
            err_cnt++;
          end
          void'(coded_q.pop_front());
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int flen;
    int n_rand;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    crc_acc         = '0;
    line_phase      = 1'b0;
    n_taken         = 0;
    err_cnt         = 0;
    quiet_cycles    = 0;
    in_idle_pct     = 16;
    out_idle_pct    = 58;

    // Directed: extremes, single-byte frames, runs of ones (phase held)
    // and runs of zeros (phase flips every bit)
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h01, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    add_byte(8'h31, 1'b0);
    add_byte(8'h32, 1'b0);
    add_byte(8'h33, 1'b0);
    add_byte(8'h34, 1'b1);

    // Random frames, mostly short, now and then long
    n_rand = 0;
    while (n_rand < RandItems) begin
      flen = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
      for (int i = 0; i < flen; i++) begin
        add_byte(pick_byte(), i == flen - 1);
      end
      n_rand += flen;
    end
    n_bytes = byte_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken < n_bytes / 3) @(posedge clk_i);
    in_idle_pct  = 58;
    out_idle_pct = 16;
    while (n_taken < (2 * n_bytes) / 3) @(posedge clk_i);
    in_idle_pct  = 0;
    out_idle_pct = 0;

    while (n_taken < n_bytes || coded_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (coded_q.size() != 0) begin
      $error("%0d expected words never arrived", coded_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
